// File: rtl/core/segment_axis_angle_top_defines.svh
// Assertion macros for the segment axis-angle block.
// Used by segment_axis_angle_top; expects clk_i and rst_ni in scope.
`ifndef SEGMENT_AXIS_ANGLE_TOP_DEFINES_SVH
`define SEGMENT_AXIS_ANGLE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SAVA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define SAVA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SAVA_ASSERT(lbl, prop, msg)
`define SAVA_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/core/sava_pkg.sv
// Shared types, widths and the arctangent table of the segment axis-angle block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package sava_pkg;

  localparam int unsigned XYZ_W        = 32;
  localparam int unsigned NUM_W        = 2 * XYZ_W;
  localparam int unsigned LEN_W        = 35;
  localparam int unsigned AXIS_W       = 18;
  localparam int unsigned ANGLE_W      = 24;
  localparam int unsigned RQ_BITS      = 49;
  localparam int unsigned LEN_BITS     = 33;
  localparam int unsigned SQRT_STAGES  = RQ_BITS;
  localparam int unsigned NORM_STEPS   = 6;
  localparam int unsigned NORM_TOP     = 60;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned DIV_BITS     = 18;
  localparam int unsigned DIV_W        = RQ_BITS + DIV_BITS - 1;
  localparam int unsigned ANGLE_STAGES = NORM_STEPS + CORDIC_STEPS;

  localparam logic [ANGLE_W-1:0]       ANGLE_MAX = 24'd11796480;
  localparam logic signed [AXIS_W-1:0] AXIS_ONE  = 18'sd65536;
  localparam logic [16:0]              Q_ONE     = 17'd65536;
  localparam logic signed [31:0]       Z_90      = 32'sd1509949440;
  localparam logic [31:0]              Z_180     = 32'd3019898880;

  typedef struct packed {
    logic dx_neg;
    logic dx_pos;
    logic dy_neg;
    logic dz_neg;
  } sava_sign_t;

  typedef struct packed {
    sava_sign_t         sign;
    logic               syz_zero;
    logic [XYZ_W-1:0]   xmag;
    logic [XYZ_W-1:0]   ymag;
    logic [XYZ_W-1:0]   zmag;
    logic [NUM_W+1:0]   sall;
    logic [NUM_W:0]     syz;
  } sava_front_t;

  typedef struct packed {
    sava_sign_t              sign;
    logic                    syz_zero;
    logic [XYZ_W-1:0]        xmag;
    logic [XYZ_W-1:0]        ymag;
    logic [XYZ_W-1:0]        zmag;
    logic [2*RQ_BITS-2:0]    rq_rem;
    logic [RQ_BITS-1:0]      rq_root;
    logic [2*LEN_BITS-1:0]   len_rem;
    logic [LEN_BITS-1:0]     len_root;
  } sava_sq_t;

  typedef struct packed {
    sava_sign_t          sign;
    logic                syz_zero;
    logic [LEN_BITS-1:0] len;
    logic [RQ_BITS-1:0]  rq;
    logic [63:0]         x;
    logic [63:0]         y;
    logic signed [31:0]  z;
    logic [NUM_W-1:0]    remy;
    logic [NUM_W-1:0]    remz;
    logic [DIV_BITS-1:0] qy;
    logic [DIV_BITS-1:0] qz;
  } sava_ang_t;

  function automatic logic signed [31:0] atan_q24(input int unsigned idx);
    case (idx)
      0:       return 32'sd754974720;
      1:       return 32'sd445687602;
      2:       return 32'sd235489088;
      3:       return 32'sd119537938;
      4:       return 32'sd60000934;
      5:       return 32'sd30029717;
      6:       return 32'sd15018523;
      7:       return 32'sd7509720;
      8:       return 32'sd3754917;
      9:       return 32'sd1877466;
      10:      return 32'sd938734;
      11:      return 32'sd469367;
      12:      return 32'sd234684;
      13:      return 32'sd117342;
      14:      return 32'sd58671;
      15:      return 32'sd29335;
      16:      return 32'sd14668;
      17:      return 32'sd7334;
      18:      return 32'sd3667;
      19:      return 32'sd1833;
      20:      return 32'sd917;
      21:      return 32'sd458;
      22:      return 32'sd229;
      23:      return 32'sd115;
      default: return 32'sd0;
    endcase
  endfunction

endpackage

// File: rtl/core/sava_front.sv
// Front end: differences, magnitudes, squares and sums of squares, five stages.
// Depends on sava_pkg.
`timescale 1ns / 1ps
module sava_front import sava_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [XYZ_W-1:0] start_x_i,
  input  logic signed [XYZ_W-1:0] start_y_i,
  input  logic signed [XYZ_W-1:0] start_z_i,
  input  logic signed [XYZ_W-1:0] end_x_i,
  input  logic signed [XYZ_W-1:0] end_y_i,
  input  logic signed [XYZ_W-1:0] end_z_i,
  output logic                    valid_o,
  output sava_front_t             data_o
);

  logic [4:0]       valid_q;
  logic [XYZ_W:0]   dx_q, dy_q, dz_q;
  logic [XYZ_W:0]   ndx, ndy, ndz;
  sava_sign_t       sign_d, sign_b_q, sign_c_q, sign_d_q;
  logic [XYZ_W-1:0] xm_d, ym_d, zm_d;
  logic [XYZ_W-1:0] xm_b_q, ym_b_q, zm_b_q;
  logic [XYZ_W-1:0] xm_c_q, ym_c_q, zm_c_q;
  logic [XYZ_W-1:0] xm_d_q, ym_d_q, zm_d_q;
  logic [NUM_W-1:0] sqx_q, sqy_q, sqz_q, sqx_d_q;
  logic [NUM_W:0]   syz_q;
  sava_front_t      out_d, out_q;

  always_comb begin
    ndx = '0 - dx_q;
    ndy = '0 - dy_q;
    ndz = '0 - dz_q;
    sign_d.dx_neg = dx_q[XYZ_W];
    sign_d.dx_pos = !dx_q[XYZ_W] && (dx_q != '0);
    sign_d.dy_neg = dy_q[XYZ_W];
    sign_d.dz_neg = dz_q[XYZ_W];
    xm_d = dx_q[XYZ_W] ? ndx[XYZ_W-1:0] : dx_q[XYZ_W-1:0];
    ym_d = dy_q[XYZ_W] ? ndy[XYZ_W-1:0] : dy_q[XYZ_W-1:0];
    zm_d = dz_q[XYZ_W] ? ndz[XYZ_W-1:0] : dz_q[XYZ_W-1:0];
  end

  always_comb begin
    out_d.sign     = sign_d_q;
    out_d.syz_zero = (syz_q == '0);
    out_d.xmag     = xm_d_q;
    out_d.ymag     = ym_d_q;
    out_d.zmag     = zm_d_q;
    out_d.sall     = {1'b0, syz_q} + {2'b00, sqx_d_q};
    out_d.syz      = syz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q     <= {end_x_i[XYZ_W-1], end_x_i} - {start_x_i[XYZ_W-1], start_x_i};
      dy_q     <= {end_y_i[XYZ_W-1], end_y_i} - {start_y_i[XYZ_W-1], start_y_i};
      dz_q     <= {end_z_i[XYZ_W-1], end_z_i} - {start_z_i[XYZ_W-1], start_z_i};
      sign_b_q <= sign_d;
      xm_b_q   <= xm_d;
      ym_b_q   <= ym_d;
      zm_b_q   <= zm_d;
      sqx_q    <= NUM_W'(xm_b_q) * NUM_W'(xm_b_q);
      sqy_q    <= NUM_W'(ym_b_q) * NUM_W'(ym_b_q);
      sqz_q    <= NUM_W'(zm_b_q) * NUM_W'(zm_b_q);
      sign_c_q <= sign_b_q;
      xm_c_q   <= xm_b_q;
      ym_c_q   <= ym_b_q;
      zm_c_q   <= zm_b_q;
      syz_q    <= {1'b0, sqy_q} + {1'b0, sqz_q};
      sqx_d_q  <= sqx_q;
      sign_d_q <= sign_c_q;
      xm_d_q   <= xm_c_q;
      ym_d_q   <= ym_c_q;
      zm_d_q   <= zm_c_q;
      out_q    <= out_d;
    end
  end

  assign valid_o = valid_q[4];
  assign data_o  = out_q;

endmodule

// File: rtl/core/sava_sqrt.sv
// Bit-per-stage square roots of the full and the y-z sums of squares.
// Depends on sava_pkg.
`timescale 1ns / 1ps
module sava_sqrt import sava_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  sava_front_t data_i,
  output logic        valid_o,
  output sava_sq_t    data_o
);

  logic [SQRT_STAGES-1:0] valid_q;
  sava_sq_t               st_q [SQRT_STAGES];
  sava_sq_t               head;

  always_comb begin
    head.sign     = data_i.sign;
    head.syz_zero = data_i.syz_zero;
    head.xmag     = data_i.xmag;
    head.ymag     = data_i.ymag;
    head.zmag     = data_i.zmag;
    head.rq_rem   = {data_i.syz, 32'b0};
    head.rq_root  = '0;
    head.len_rem  = data_i.sall;
    head.len_root = '0;
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int  RB     = int'(RQ_BITS) - 1 - k;
    localparam bit  LEN_ON = (k < int'(LEN_BITS));
    localparam int  LB     = LEN_ON ? int'(LEN_BITS) - 1 - k : 0;
    sava_sq_t                cur, nxt;
    logic [2*RQ_BITS-1:0]    rq_trial;
    logic [2*LEN_BITS:0]     len_trial;

    if (k == 0) begin : g_first
      assign cur = head;
    end else begin : g_next
      assign cur = st_q[k-1];
    end

    always_comb begin
      nxt       = cur;
      rq_trial  = ({{RQ_BITS{1'b0}}, cur.rq_root} << (RB + 1)) |
                  ((2*RQ_BITS)'(1) << (2 * RB));
      len_trial = ({{(LEN_BITS+1){1'b0}}, cur.len_root} << (LB + 1)) |
                  ((2*LEN_BITS+1)'(1) << (2 * LB));
      if ({1'b0, cur.rq_rem} >= rq_trial) begin
        nxt.rq_rem  = cur.rq_rem - rq_trial[2*RQ_BITS-2:0];
        nxt.rq_root = cur.rq_root | (RQ_BITS'(1) << RB);
      end
      if (LEN_ON && ({1'b0, cur.len_rem} >= len_trial)) begin
        nxt.len_rem  = cur.len_rem - len_trial[2*LEN_BITS-1:0];
        nxt.len_root = cur.len_root | (LEN_BITS'(1) << LB);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[SQRT_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[SQRT_STAGES-1];
  assign data_o  = st_q[SQRT_STAGES-1];

endmodule

// File: rtl/core/sava_angle.sv
// Normalizing shift, CORDIC vectoring for the angle and restoring division
// for the axis components, one step per stage. Depends on sava_pkg.
`timescale 1ns / 1ps
module sava_angle import sava_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  sava_sq_t  data_i,
  output logic      valid_o,
  output sava_ang_t data_o
);

  logic [ANGLE_STAGES-1:0] valid_q;
  sava_ang_t               st_q [ANGLE_STAGES];
  sava_ang_t               head;

  always_comb begin
    head.sign     = data_i.sign;
    head.syz_zero = data_i.syz_zero;
    head.len      = data_i.len_root;
    head.rq       = data_i.rq_root;
    head.x        = {16'b0, data_i.xmag, 16'b0};
    head.y        = {{(64-RQ_BITS){1'b0}}, data_i.rq_root};
    head.z        = '0;
    head.remy     = {data_i.ymag, {XYZ_W{1'b0}}};
    head.remz     = {data_i.zmag, {XYZ_W{1'b0}}};
    head.qy       = '0;
    head.qz       = '0;
  end

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_stage
    localparam bit IS_NORM = (k < int'(NORM_STEPS));
    localparam int NS      = IS_NORM ? (2 ** (int'(NORM_STEPS) - 1 - k)) : 0;
    localparam int CI      = IS_NORM ? 0 : k - int'(NORM_STEPS);
    localparam bit IS_DIV  = (k < int'(DIV_BITS));
    localparam int DJ      = IS_DIV ? int'(DIV_BITS) - 1 - k : 0;
    sava_ang_t        cur, nxt;
    logic [63:0]      xs, ys;
    logic [DIV_W-1:0] dtrial;

    if (k == 0) begin : g_first
      assign cur = head;
    end else begin : g_next
      assign cur = st_q[k-1];
    end

    always_comb begin
      nxt    = cur;
      xs     = 64'($signed(cur.x) >>> CI);
      ys     = 64'($signed(cur.y) >>> CI);
      dtrial = {{(DIV_BITS-1){1'b0}}, cur.rq} << DJ;
      if (IS_NORM) begin
        if (((cur.x | cur.y) >> (int'(NORM_TOP) - NS)) == '0) begin
          nxt.x = cur.x << NS;
          nxt.y = cur.y << NS;
        end
      end else if (!cur.y[63]) begin
        nxt.x = cur.x + ys;
        nxt.y = cur.y - xs;
        nxt.z = cur.z + atan_q24(CI);
      end else begin
        nxt.x = cur.x - ys;
        nxt.y = cur.y + xs;
        nxt.z = cur.z - atan_q24(CI);
      end
      if (IS_DIV) begin
        if ({{(DIV_W-NUM_W){1'b0}}, cur.remy} >= dtrial) begin
          nxt.remy = cur.remy - dtrial[NUM_W-1:0];
          nxt.qy   = cur.qy | (DIV_BITS'(1) << DJ);
        end
        if ({{(DIV_W-NUM_W){1'b0}}, cur.remz} >= dtrial) begin
          nxt.remz = cur.remz - dtrial[NUM_W-1:0];
          nxt.qz   = cur.qz | (DIV_BITS'(1) << DJ);
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[ANGLE_STAGES-2:0], valid_i};
    end
  end

  assign valid_o = valid_q[ANGLE_STAGES-1];
  assign data_o  = st_q[ANGLE_STAGES-1];

endmodule

// File: rtl/core/sava_final.sv
// Angle clamp, mirror and rounding, axis clamp and sign, degenerate cases and
// the output register. Depends on sava_pkg.
`timescale 1ns / 1ps
module sava_final import sava_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  sava_ang_t                data_i,
  output logic                     valid_o,
  output logic [LEN_W-1:0]         seg_length_o,
  output logic signed [AXIS_W-1:0] axis_x_o,
  output logic signed [AXIS_W-1:0] axis_y_o,
  output logic [ANGLE_W-1:0]       angle_deg_o
);

  logic                      valid1_q, valid2_q;
  logic signed [31:0]        zc;
  logic [31:0]               zu_d, zu_q;
  logic [16:0]               qy_d, qz_d, qy_q, qz_q;
  sava_sign_t                sign_q;
  logic                      zero_q;
  logic [LEN_BITS-1:0]       len_q;
  logic [32:0]               rnd;
  logic [ANGLE_W-1:0]        ang_d, ang_q;
  logic signed [AXIS_W-1:0]  qy_s, qz_s;
  logic signed [AXIS_W-1:0]  ax_d, ay_d, ax_q, ay_q;
  logic [LEN_W-1:0]          len_out_q;

  always_comb begin
    if (data_i.z < 0) begin
      zc = '0;
    end else if (data_i.z > Z_90) begin
      zc = Z_90;
    end else begin
      zc = data_i.z;
    end
    zu_d = data_i.sign.dx_neg ? (Z_180 - $unsigned(zc)) : $unsigned(zc);
    qy_d = (data_i.qy > DIV_BITS'(Q_ONE)) ? Q_ONE : data_i.qy[16:0];
    qz_d = (data_i.qz > DIV_BITS'(Q_ONE)) ? Q_ONE : data_i.qz[16:0];
  end

  always_comb begin
    rnd  = {1'b0, zu_q} + 33'd128;
    qy_s = $signed({1'b0, qy_q});
    qz_s = $signed({1'b0, qz_q});
    if (rnd[32:8] > {1'b0, ANGLE_MAX}) begin
      ang_d = ANGLE_MAX;
    end else begin
      ang_d = rnd[31:8];
    end
    ax_d = sign_q.dz_neg ? qz_s : -qz_s;
    ay_d = sign_q.dy_neg ? -qy_s : qy_s;
    if (zero_q) begin
      ax_d = '0;
      if (sign_q.dx_pos) begin
        ay_d  = '0;
        ang_d = '0;
      end else begin
        ay_d  = AXIS_ONE;
        ang_d = ANGLE_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zu_q      <= zu_d;
      qy_q      <= qy_d;
      qz_q      <= qz_d;
      sign_q    <= data_i.sign;
      zero_q    <= data_i.syz_zero;
      len_q     <= data_i.len;
      ang_q     <= ang_d;
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      len_out_q <= {{(LEN_W-LEN_BITS){1'b0}}, len_q};
    end
  end

  assign valid_o      = valid2_q;
  assign seg_length_o = len_out_q;
  assign axis_x_o     = ax_q;
  assign axis_y_o     = ay_q;
  assign angle_deg_o  = ang_q;

endmodule

// File: rtl/core/segment_axis_angle_top.sv
// Top level of the segment axis-angle block: front end, square roots,
// CORDIC and divider, output stage. Depends on sava_pkg and the defines header.
//
//   Channel  Direction  Handshake                Payload
//   in       sink       in_valid_i / in_ready_o  start_x/y/z_i, end_x/y/z_i
//   out      source     out_valid_o / out_ready_i seg_length_o, axis_x/y_o, angle_deg_o
//
// One transfer per cycle in each direction while the output is not stalled; the
// pipeline has 49 root stages, 6 shift and 24 CORDIC stages plus 7 front and output stages.
// Reset clears only the valid bits of the pipeline.
// A stall on the output freezes every stage at once; in_ready_o follows it.
`timescale 1ns / 1ps
`include "segment_axis_angle_top_defines.svh"
module segment_axis_angle_top import sava_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [XYZ_W-1:0]  start_x_i,
  input  logic signed [XYZ_W-1:0]  start_y_i,
  input  logic signed [XYZ_W-1:0]  start_z_i,
  input  logic signed [XYZ_W-1:0]  end_x_i,
  input  logic signed [XYZ_W-1:0]  end_y_i,
  input  logic signed [XYZ_W-1:0]  end_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [LEN_W-1:0]         seg_length_o,
  output logic signed [AXIS_W-1:0] axis_x_o,
  output logic signed [AXIS_W-1:0] axis_y_o,
  output logic [ANGLE_W-1:0]       angle_deg_o
);

  logic        en;
  logic        front_valid, sqrt_valid, ang_valid;
  sava_front_t front_data;
  sava_sq_t    sqrt_data;
  sava_ang_t   ang_data;

  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  sava_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .start_z_i (start_z_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .end_z_i   (end_z_i),
    .valid_o   (front_valid),
    .data_o    (front_data)
  );

  sava_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .data_i  (front_data),
    .valid_o (sqrt_valid),
    .data_o  (sqrt_data)
  );

  sava_angle u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .data_i  (sqrt_data),
    .valid_o (ang_valid),
    .data_o  (ang_data)
  );

  sava_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (ang_valid),
    .data_i       (ang_data),
    .valid_o      (out_valid_o),
    .seg_length_o (seg_length_o),
    .axis_x_o     (axis_x_o),
    .axis_y_o     (axis_y_o),
    .angle_deg_o  (angle_deg_o)
  );

  `SAVA_ASSERT(a_angle_range, out_valid_o |-> (angle_deg_o <= ANGLE_MAX), "angle out of range")
  `SAVA_ASSERT(a_axis_range, out_valid_o |-> (axis_x_o <= AXIS_ONE) && (axis_x_o >= -AXIS_ONE) && (axis_y_o <= AXIS_ONE) && (axis_y_o >= -AXIS_ONE), "axis out of range")
  `SAVA_ASSERT_NEVER(a_zero_len, out_valid_o && (seg_length_o == '0) && ((angle_deg_o != ANGLE_MAX) || (axis_y_o != AXIS_ONE) || (axis_x_o != '0)), "zero-length segment result wrong")

endmodule

// File: sim/segment_axis_angle_top_test.sv
// Self-checking testbench for segment_axis_angle_top: drives segments through the
// valid/ready input channel and checks every output transfer against a local model.
// Depends on sava_pkg and the segment_axis_angle_top RTL.
`timescale 1ns / 1ps
module segment_axis_angle_top_test;
  import sava_pkg::*;

  typedef struct {
    logic [LEN_W-1:0]         len;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic [ANGLE_W-1:0]       ang;
  } pose_t;

  localparam longint ATAN_DEG[24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115
  };
  localparam logic [63:0] LEN_LIMIT = 64'd34359738367;
  localparam longint      DEG_ONE   = 64'sd16777216;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [XYZ_W-1:0] start_x_i = '0, start_y_i = '0, start_z_i = '0;
  logic signed [XYZ_W-1:0] end_x_i = '0, end_y_i = '0, end_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [LEN_W-1:0] seg_length_o;
  logic signed [AXIS_W-1:0] axis_x_o, axis_y_o;
  logic [ANGLE_W-1:0] angle_deg_o;

  pose_t pending_poses[$];
  int    errors = 0;
  bit    stall_en = 1'b1;

  segment_axis_angle_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [63:0] root128(input logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic longint unit_part(input longint c, input logic [63:0] rq);
    logic [63:0] q, m;
    m = (c < 0) ? -c : c;
    q = (m << 32) / rq;
    if (q > 64'd65536) q = 64'd65536;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [ANGLE_W-1:0] rot_angle(input longint dx, input logic [63:0] rq);
    logic [63:0] ux, uy, a;
    longint x, y, z, xs, ys;
    ux = ((dx < 0) ? -dx : dx) << 16;
    uy = rq;
    while (((ux > uy) ? ux : uy) < (64'd1 << 59)) begin
      ux = ux << 1;
      uy = uy << 1;
    end
    x = ux;
    y = uy;
    z = 0;
    for (int i = 0; i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_DEG[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_DEG[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * DEG_ONE) z = 90 * DEG_ONE;
    if (dx < 0) z = 180 * DEG_ONE - z;
    a = (z + 128) >> 8;
    if (a > ANGLE_MAX) a = ANGLE_MAX;
    return a[ANGLE_W-1:0];
  endfunction

  function automatic pose_t segment_pose(input logic signed [31:0] sx, sy, sz, ex, ey, ez);
    pose_t p;
    longint dx, dy, dz;
    logic [127:0] syz, sall;
    logic [63:0] len, rq, mx, my, mz;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    dz = longint'(ez) - longint'(sz);
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    mz = (dz < 0) ? -dz : dz;
    syz = {64'd0, my} * {64'd0, my} + {64'd0, mz} * {64'd0, mz};
    sall = syz + {64'd0, mx} * {64'd0, mx};
    len = root128(sall);
    if (len > LEN_LIMIT) len = LEN_LIMIT;
    p.len = len[LEN_W-1:0];
    if (syz != 0) begin
      rq = root128(syz << 32);
      p.ax = AXIS_W'(-unit_part(dz, rq));
      p.ay = AXIS_W'(unit_part(dy, rq));
      p.ang = rot_angle(dx, rq);
    end else begin
      p.ax = '0;
      if (dx > 0) begin
        p.ay = '0; p.ang = '0;
      end else begin
        p.ay = AXIS_ONE; p.ang = ANGLE_MAX;
      end
    end
    return p;
  endfunction

  task automatic send_segment(input logic signed [31:0] sx, sy, sz, ex, ey, ez);
    int gap;
    gap = stall_en ? $urandom_range(0, 8) : 0;
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    start_x_i = sx; start_y_i = sy; start_z_i = sz;
    end_x_i = ex; end_y_i = ey; end_z_i = ez;
    do @(posedge clk_i); while (!in_ready_o);
    pending_poses.push_back(segment_pose(sx, sy, sz, ex, ey, ez));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_random_segment();
    logic signed [31:0] v[6];
    int kind;
    kind = $urandom_range(0, 9);
    foreach (v[i]) v[i] = $urandom;
    case (kind)
      0, 1: foreach (v[i]) v[i] = $signed($urandom_range(0, 2000)) - 1000;
      2: begin
        v[4] = v[1]; v[5] = v[2];
      end
      3: v[3:5] = v[0:2];
      4: foreach (v[i]) v[i] = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      5: begin
        v[4] = v[1] + $signed($urandom_range(0, 4)) - 2;
        v[5] = v[2] + $signed($urandom_range(0, 4)) - 2;
      end
      default: ;
    endcase
    send_segment(v[0], v[1], v[2], v[3], v[4], v[5]);
  endtask

  task automatic test_degenerate();
    send_segment(0, 0, 0, 0, 0, 0);
    send_segment(32'h12345678, -5, 77, 32'h12345678, -5, 77);
    send_segment(0, 0, 0, 32'sd65536, 0, 0);
    send_segment(0, 0, 0, -32'sd65536, 0, 0);
    send_segment(32'h80000000, 9, 9, 32'h7fffffff, 9, 9);
    send_segment(32'h7fffffff, 9, 9, 32'h80000000, 9, 9);
  endtask

  task automatic test_extremes();
    send_segment(32'h80000000, 32'h80000000, 32'h80000000,
                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_segment(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000);
    send_segment(0, 32'h80000000, 0, 0, 32'h7fffffff, 0);
    send_segment(0, 0, 32'h7fffffff, 0, 0, 32'h80000000);
    send_segment(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0);
  endtask

  task automatic test_axis_directions();
    send_segment(0, 0, 0, 0, 32'sd65536, 0);
    send_segment(0, 0, 0, 0, -32'sd65536, 0);
    send_segment(0, 0, 0, 0, 0, 32'sd65536);
    send_segment(0, 0, 0, 0, 0, -32'sd65536);
    send_segment(0, 0, 0, 1, 1, 0);
    send_segment(0, 0, 0, 0, 1, 0);
    send_segment(0, 0, 0, -1, 0, 1);
    send_segment(0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536);
    send_segment(0, 0, 0, 32'h7fffffff, 0, 1);
    send_segment(0, 0, 0, 32'h80000000, 1, 0);
  endtask

  task automatic test_random_stream();
    stall_en = 1'b0;
    repeat (100) send_random_segment();
    stall_en = 1'b1;
    repeat (750) send_random_segment();
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (stall_en && $urandom_range(0, 3) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_poses.size() == 0) begin
        $display("%t: unexpected transfer len=%0d", $time, seg_length_o);
        errors++;
      end else begin
        e = pending_poses.pop_front();
        if (seg_length_o !== e.len) begin
          $display("%t: seg_length expected %0d actual %0d", $time, e.len, seg_length_o);
          errors++;
        end
        if (axis_x_o !== e.ax) begin
          $display("%t: axis_x expected %0d actual %0d", $time, e.ax, axis_x_o);
          errors++;
        end
        if (axis_y_o !== e.ay) begin
          $display("%t: axis_y expected %0d actual %0d", $time, e.ay, axis_y_o);
          errors++;
        end
        if (angle_deg_o !== e.ang) begin
          $display("%t: angle_deg expected %0d actual %0d", $time, e.ang, angle_deg_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    test_degenerate();
    test_extremes();
    test_axis_directions();
    test_random_stream();
    while (pending_poses.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
    if (errors == 0 && pending_poses.size() == 0) begin
      $display("** segment_axis_angle_top: PASSED **");
    end else begin
      $display("** segment_axis_angle_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** segment_axis_angle_top: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sava_pkg.sv
rtl/core/sava_front.sv
rtl/core/sava_sqrt.sv
rtl/core/sava_angle.sv
rtl/core/sava_final.sv
rtl/core/segment_axis_angle_top.sv
sim/segment_axis_angle_top_test.sv
